// ===== src/track_sector_to_block_address_defines.svh =====
// Assertion macros shared by the track and sector address mapper.
`ifndef TRACK_SECTOR_TO_BLOCK_ADDRESS_DEFINES_SVH
`define TRACK_SECTOR_TO_BLOCK_ADDRESS_DEFINES_SVH

// Checked only while reset is released.
`define TSBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TSBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/tsba_pkg.sv =====
// Package with widths, format codes and zone layout functions of the address mapper.
package tsba_pkg;

  localparam int unsigned TrackW  = 8;
  localparam int unsigned SectorW = 8;
  localparam int unsigned BlockW  = 13;
  localparam int unsigned OffsetW = 21;
  localparam int unsigned CountW  = 8;
  localparam int unsigned SptW    = 6;
  localparam int unsigned FmtW    = 3;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;

  localparam logic [FmtW-1:0] FmtNone  = 3'd0;
  localparam logic [FmtW-1:0] FmtD64S  = 3'd1;
  localparam logic [FmtW-1:0] FmtD64L  = 3'd2;
  localparam logic [FmtW-1:0] FmtD64X  = 3'd3;
  localparam logic [FmtW-1:0] FmtD71   = 3'd4;
  localparam logic [FmtW-1:0] FmtD81   = 3'd5;
  localparam logic [FmtW-1:0] FmtD80   = 3'd6;
  localparam logic [FmtW-1:0] FmtD82   = 3'd7;

  localparam logic [BlockW-1:0] Side35Blocks = 13'd683;
  localparam logic [BlockW-1:0] Side77Blocks = 13'd2083;

  typedef struct packed {
    logic [SptW-1:0]   spt;
    logic [BlockW-1:0] base;
  } zone_t;

  // Zoned layout of one 35 track side.
  function automatic zone_t zone35(input logic [TrackW-1:0] t);
    zone_t             z;
    logic [BlockW-1:0] tw;
    tw = {{(BlockW-TrackW){1'b0}}, t};
    if (t < 8'd18) begin
      z.spt  = 6'd21;
      z.base = BlockW'((tw - 13'd1) * 13'd21);
    end else if (t < 8'd25) begin
      z.spt  = 6'd19;
      z.base = BlockW'((tw - 13'd18) * 13'd19 + 13'd357);
    end else if (t < 8'd31) begin
      z.spt  = 6'd18;
      z.base = BlockW'((tw - 13'd25) * 13'd18 + 13'd490);
    end else begin
      z.spt  = 6'd17;
      z.base = BlockW'((tw - 13'd31) * 13'd17 + 13'd598);
    end
    return z;
  endfunction

  // Zoned layout of one 77 track side.
  function automatic zone_t zone77(input logic [TrackW-1:0] t);
    zone_t             z;
    logic [BlockW-1:0] tw;
    tw = {{(BlockW-TrackW){1'b0}}, t};
    if (t < 8'd40) begin
      z.spt  = 6'd29;
      z.base = BlockW'((tw - 13'd1) * 13'd29);
    end else if (t < 8'd54) begin
      z.spt  = 6'd27;
      z.base = BlockW'((tw - 13'd40) * 13'd27 + 13'd1131);
    end else if (t < 8'd65) begin
      z.spt  = 6'd25;
      z.base = BlockW'((tw - 13'd54) * 13'd25 + 13'd1509);
    end else begin
      z.spt  = 6'd23;
      z.base = BlockW'((tw - 13'd65) * 13'd23 + 13'd1784);
    end
    return z;
  endfunction

endpackage

// ===== src/track_sector_to_block_address.sv =====
// Top level: maps a disk image track and sector to a block index and byte offset.
//
//   Channel   Dir  Payload
//   s_axis    in   tdata: track_number, sector_number
//   m_axis    out  tdata: block_index, byte_offset, track_count, sectors_in_track;
//                  tuser: address_valid
//   cfg       in   image_format, one register
//
// Each word passes through the input register, then the result register. With the
// output taking words freely, one word is accepted every cycle. The zone lookup
// with its constant multiply sits between the two registers. Reset clears both
// valid flags and sets the format to none. A stalled output holds its word; the
// input register still takes a word while it is empty.
module track_sector_to_block_address (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsba_pkg::FmtW-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] track_number, [15:8] sector_number
  input  logic [tsba_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [12:0] block_index, [33:13] byte_offset, [41:34] track_count,
  // [47:42] sectors_in_track
  output logic [tsba_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] address_valid
  output logic                          m_axis_tuser
);

  `include "track_sector_to_block_address_defines.svh"

  logic [tsba_pkg::FmtW-1:0]    fmt_q;
  logic                         s1_valid_q;
  logic [tsba_pkg::TrackW-1:0]  track_q;
  logic [tsba_pkg::SectorW-1:0] sector_q;
  logic                         out_valid_q;
  logic [tsba_pkg::BlockW-1:0]  block_q,  block_d;
  logic                         addr_ok_q, addr_ok_d;
  logic [tsba_pkg::CountW-1:0]  count_q,  count_d;
  logic [tsba_pkg::SptW-1:0]    spt_q,    spt_d;

  logic                         out_adv;
  logic                         in_adv;
  logic [tsba_pkg::TrackW-1:0]  t_side;
  logic [tsba_pkg::BlockW-1:0]  side_off;
  logic                         use77;
  logic                         uniform;
  logic                         in_range;
  tsba_pkg::zone_t              z35, z77, zsel;

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign in_adv        = !s1_valid_q || out_adv;
  assign s_axis_tready = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= tsba_pkg::FmtNone;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      track_q  <= s_axis_tdata[7:0];
      sector_q <= s_axis_tdata[15:8];
    end
    if (out_adv && s1_valid_q) begin
      block_q   <= block_d;
      addr_ok_q <= addr_ok_d;
      count_q   <= count_d;
      spt_q     <= spt_d;
    end
  end

  always_comb begin
    count_d  = 8'd0;
    t_side   = track_q;
    side_off = '0;
    use77    = 1'b0;
    uniform  = 1'b0;
    case (fmt_q)
      tsba_pkg::FmtD64S: count_d = 8'd35;
      tsba_pkg::FmtD64L: count_d = 8'd40;
      tsba_pkg::FmtD64X: count_d = 8'd42;
      tsba_pkg::FmtD71: begin
        count_d = 8'd70;
        if (track_q > 8'd35) begin
          t_side   = track_q - 8'd35;
          side_off = tsba_pkg::Side35Blocks;
        end
      end
      tsba_pkg::FmtD81: begin
        count_d = 8'd80;
        uniform = 1'b1;
      end
      tsba_pkg::FmtD80: begin
        count_d = 8'd77;
        use77   = 1'b1;
      end
      tsba_pkg::FmtD82: begin
        count_d = 8'd154;
        use77   = 1'b1;
        if (track_q > 8'd77) begin
          t_side   = track_q - 8'd77;
          side_off = tsba_pkg::Side77Blocks;
        end
      end
      default: count_d = 8'd0;
    endcase

    z35 = tsba_pkg::zone35(t_side);
    z77 = tsba_pkg::zone77(t_side);
    if (uniform) begin
      zsel.spt  = 6'd40;
      zsel.base = tsba_pkg::BlockW'(({5'd0, track_q} - 13'd1) * 13'd40);
    end else if (use77) begin
      zsel = z77;
    end else begin
      zsel = z35;
    end

    in_range  = (track_q != 8'd0) && (track_q <= count_d);
    addr_ok_d = in_range && (sector_q < {2'b00, zsel.spt});
    spt_d     = in_range ? zsel.spt : '0;
    block_d   = addr_ok_d ? (zsel.base + side_off + {5'd0, sector_q}) : '0;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = addr_ok_q;
  assign m_axis_tdata  = {spt_q, count_q, block_q, 8'd0, block_q};

  `TSBA_ASSERT(a_invalid_zero, out_valid_q && !addr_ok_q |-> block_q == '0, "invalid word carries a nonzero block")
  `TSBA_ASSERT(a_valid_geometry, out_valid_q && addr_ok_q |-> spt_q != '0 && count_q != '0, "valid word with empty geometry")
  `TSBA_ASSERT(a_spt_bound, out_valid_q |-> spt_q <= 6'd40, "sector count beyond forty")
  `TSBA_ASSERT(a_stage_hold, s1_valid_q && out_valid_q && !m_axis_tready |=> s1_valid_q, "input stage lost a word during a stall")
  `TSBA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_q && !s1_valid_q, "pipeline not empty in reset")

endmodule

// ===== sim/tsba_address_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts the block address of each accepted word and compares the results.
module tsba_address_checker
  import tsba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [FmtW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tuser,
  input  logic                done_i,
  output int                  pending_o,
  output int                  checked_o,
  output int                  fail_count_o
);

  typedef struct packed {
    logic [BlockW-1:0]  block;
    logic [OffsetW-1:0] offset;
    logic               valid;
    logic [CountW-1:0]  count;
    logic [SptW-1:0]    spt;
  } address_t;

  address_t        expected_addr_q[$];
  logic [FmtW-1:0] image_fmt = FmtNone;
  int              failures  = 0;
  int              pending   = 0;
  int              checked   = 0;

  function automatic int tracks_of(logic [FmtW-1:0] fmt);
    case (fmt)
      FmtD64S: return 35;
      FmtD64L: return 40;
      FmtD64X: return 42;
      FmtD71:  return 70;
      FmtD81:  return 80;
      FmtD80:  return 77;
      FmtD82:  return 154;
      default: return 0;
    endcase
  endfunction

  function automatic int sectors_on(logic [FmtW-1:0] fmt, int trk);
    int k;
    k = trk;
    if (fmt == FmtD81) begin
      return 40;
    end else if (fmt == FmtD80 || fmt == FmtD82) begin
      if (fmt == FmtD82 && k > 77) k -= 77;
      if (k < 40) return 29;
      else if (k < 54) return 27;
      else if (k < 65) return 25;
      else return 23;
    end else begin
      if (fmt == FmtD71 && k > 35) k -= 35;
      if (k < 18) return 21;
      else if (k < 25) return 19;
      else if (k < 31) return 18;
      else return 17;
    end
  endfunction

  // The first block of a track is the sum of the sectors of all tracks in front of it.
  function automatic address_t map_track_sector(logic [FmtW-1:0] fmt, int trk, int sec);
    address_t a;
    int       count;
    int       spt;
    int       base;
    a     = '0;
    count = tracks_of(fmt);
    a.count = CountW'(count);
    if (trk >= 1 && trk <= count) begin
      spt  = sectors_on(fmt, trk);
      base = 0;
      for (int k = 1; k < trk; k++) base += sectors_on(fmt, k);
      a.spt = SptW'(spt);
      if (sec < spt) begin
        a.valid  = 1'b1;
        a.block  = BlockW'(base + sec);
        a.offset = OffsetW'((base + sec) * 256);
      end
    end
    return a;
  endfunction

  always @(posedge clk_i) begin
    address_t got;
    address_t want;
    if (!rst_ni) begin
      image_fmt = FmtNone;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_addr_q.push_back(map_track_sector(image_fmt,
            int'(s_axis_tdata[TrackW-1:0]), int'(s_axis_tdata[TrackW +: SectorW])));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.block  = m_axis_tdata[BlockW-1:0];
        got.offset = m_axis_tdata[BlockW +: OffsetW];
        got.count  = m_axis_tdata[BlockW+OffsetW +: CountW];
        got.spt    = m_axis_tdata[BlockW+OffsetW+CountW +: SptW];
        got.valid  = m_axis_tuser;
        checked++;
        if (expected_addr_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected word, block %0d offset %0d valid %0b tracks %0d sectors %0d",
                     $time, got.block, got.offset, got.valid, got.count, got.spt);
        end else begin
          want = expected_addr_q.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: mismatch, expected block %0d offset %0d valid %0b tracks %0d sectors %0d",
                       $time, want.block, want.offset, want.valid, want.count, want.spt);
              $display("%0t:           got block %0d offset %0d valid %0b tracks %0d sectors %0d",
                       $time, got.block, got.offset, got.valid, got.count, got.spt);
            end
          end
        end
      end
      if (cfg_we_i) image_fmt = cfg_wdata_i;
    end
    pending = expected_addr_q.size();
  end

  assign pending_o    = pending;
  assign checked_o    = checked;
  assign fail_count_o = failures + (done_i ? pending : 0);

endmodule

// ===== sim/tb_track_sector_to_block_address.sv =====
`timescale 1ns / 100ps
// Testbench top that drives track and sector words through the address mapper and gives the verdict.
module tb_track_sector_to_block_address;
  import tsba_pkg::*;

  typedef struct {
    logic [FmtW-1:0] fmt;
    int              trk;
    int              sec;
  } probe_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [FmtW-1:0]     cfg_wdata_i   = FmtNone;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                done          = 1'b0;

  int              sender_idle_pct    = 0;
  int              receiver_stall_pct = 0;
  int              words_sent         = 0;
  int              pending;
  int              checked;
  int              fail_count;
  logic [FmtW-1:0] cur_fmt            = FmtNone;

  probe_t probes [28] = '{
    '{FmtNone, 1, 0},   '{FmtNone, 255, 255},
    '{FmtD64S, 1, 0},   '{FmtD64S, 1, 20},    '{FmtD64S, 1, 21},   '{FmtD64S, 18, 18},
    '{FmtD64S, 24, 19}, '{FmtD64S, 25, 17},   '{FmtD64S, 31, 0},   '{FmtD64S, 35, 16},
    '{FmtD64S, 36, 0},  '{FmtD64S, 0, 0},     '{FmtD64S, 255, 255},
    '{FmtD64L, 40, 16}, '{FmtD64L, 41, 0},
    '{FmtD64X, 42, 16}, '{FmtD64X, 42, 17},
    '{FmtD71, 36, 0},   '{FmtD71, 70, 16},
    '{FmtD81, 80, 39},  '{FmtD81, 80, 40},
    '{FmtD80, 77, 22},  '{FmtD80, 39, 28},    '{FmtD80, 40, 27},
    '{FmtD82, 78, 0},   '{FmtD82, 154, 22},   '{FmtD82, 155, 0},   '{FmtD82, 0, 255}
  };

  track_sector_to_block_address dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tsba_address_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .done_i        (done),
    .pending_o     (pending),
    .checked_o     (checked),
    .fail_count_o  (fail_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic int track_limit(logic [FmtW-1:0] fmt);
    case (fmt)
      FmtD64S: return 35;
      FmtD64L: return 40;
      FmtD64X: return 42;
      FmtD71:  return 70;
      FmtD81:  return 80;
      FmtD80:  return 77;
      FmtD82:  return 154;
      default: return 0;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the word was taken.
  task automatic send_word(int trk, int sec);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sec[SectorW-1:0], trk[TrackW-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_format(logic [FmtW-1:0] fmt);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fmt;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_fmt = fmt;
    @(negedge clk_i);
  endtask

  // Mostly tracks of the current format, some just outside it, the rest anywhere.
  task automatic send_random_word();
    int r;
    int hi;
    int trk;
    int sec;
    r  = $urandom_range(99);
    hi = track_limit(cur_fmt);
    if (r < 65) begin
      trk = $urandom_range((hi > 0) ? hi : 3, 1);
      sec = $urandom_range(40, 0);
    end else if (r < 80) begin
      trk = ($urandom_range(1) == 0) ? 0 : hi + $urandom_range(3, 1);
      sec = $urandom_range(255);
    end else begin
      trk = $urandom_range(255);
      sec = $urandom_range(255);
    end
    send_word(trk, sec);
  endtask

  initial begin
    int wait_cycles;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (probes[i]) begin
      if (i == 0 || probes[i].fmt != cur_fmt) write_format(probes[i].fmt);
      send_word(probes[i].trk, probes[i].sec);
    end

    for (int seg = 0; seg < 16; seg++) begin
      case ((seg / 4) % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
        default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
      endcase
      write_format(FmtW'(seg % 8));
      repeat (90) send_random_word();
    end

    s_axis_tvalid <= 1'b0;
    receiver_stall_pct = 0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(negedge clk_i);
    done <= 1'b1;
    @(negedge clk_i);

    $display("Sent %0d words and checked %0d results over all eight image formats,",
             words_sent, checked);
    $display("with zone edges, out-of-range tracks and sectors, and four idle and stall mixes.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding.", pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
